@@ rtl/core/rsi_pkg.sv @@
// Shared types, widths and helpers for the ray/sphere intersection pipeline.
// No dependencies; every rtl/core module imports this package.
package rsi_pkg;

    localparam int XW  = 32;   // coordinate field width
    localparam int RW  = 31;   // radius width
    localparam int AW  = 48;   // quadratic term A = |d|^2
    localparam int HW  = 51;   // half linear term H and constant term C, signed
    localparam int LW  = 26;   // low slice for split multiplies
    localparam int PW  = 102;  // assembled wide products
    localparam int DW  = 101;  // discriminant
    localparam int SW  = 50;   // square root bits
    localparam int NW  = 52;   // root numerators
    localparam int TW  = 32;   // ray parameter t, Q16.16 unsigned
    localparam int PAW = 4;    // APB address width

    typedef logic signed [XW-1:0] t_coord;

    typedef enum logic [1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_RADIUS
    } t_reg_idx;

    typedef struct packed {
        t_coord ox;
        t_coord oy;
        t_coord oz;
        t_coord dx;
        t_coord dy;
        t_coord dz;
    } t_ray;

    typedef struct packed {
        t_ray                   ray;
        logic signed [HW-1:0]   h;
        logic [AW-1:0]          a;
        logic                   miss;
    } t_sq_side;

    typedef struct packed {
        logic   hit;
        t_coord px;
        t_coord py;
        t_coord pz;
        t_coord nx;
        t_coord ny;
        t_coord nz;
    } t_result;

    // clamp to a signed range of cw bits, cw at most XW
    function automatic t_coord sat_cw(input logic signed [63:0] x, input int cw);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [63:0] y;
        hi = (64'sd1 <<< (cw - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi) begin
            y = hi;
        end else if (x < lo) begin
            y = lo;
        end else begin
            y = x;
        end
        return y[XW-1:0];
    endfunction

endpackage

@@ rtl/core/rsi_quad.sv @@
// Front end: forms A, H, C of the ray/sphere quadratic and its discriminant.
// Six register stages; uses rsi_pkg.
module rsi_quad #(
    parameter int CW = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_vld,
    input  rsi_pkg::t_ray            i_ray,
    input  rsi_pkg::t_coord          i_cx,
    input  rsi_pkg::t_coord          i_cy,
    input  rsi_pkg::t_coord          i_cz,
    input  logic [rsi_pkg::RW-1:0]   i_radius,
    output logic                     o_vld,
    output rsi_pkg::t_sq_side        o_side,
    output logic [rsi_pkg::DW-1:0]   o_disc
);
    import rsi_pkg::*;

    t_coord                 w_c [3];
    t_coord                 w_o [3];
    t_coord                 w_d [3];
    t_coord                 r1_d [3];
    t_ray                   w_ray;
    logic [5:0]             r_vld;
    t_ray                   r1_ray, r2_ray, r3_ray, r4_ray, r5_ray;
    logic signed [XW:0]     w_oc [3];
    logic [XW:0]            r1_ocabs [3];
    logic signed [XW:0]     r1_oc [3];
    logic signed [2*XW:0]   r2_doc [3];
    logic [2*XW-1:0]        r2_dd [3];
    logic [2*XW+1:0]        r2_oc2 [3];
    logic [2*RW-1:0]        r2_rr;
    logic [AW-1:0]          r3_a, r4_a, r5_a;
    logic signed [HW-1:0]   r3_h, r4_h, r5_h, r3_c;
    logic [HW-1:0]          w_habs, w_cabs;
    logic [2*LW-1:0]        r4_hll, r4_hlh, r4_hhh, r4_acll, r4_aclh, r4_achl, r4_achh;
    logic                   r4_cle0, r4_azero, r5_cle0, r5_azero;
    logic [PW-1:0]          r5_h2, r5_ac;
    t_sq_side               r6_side;
    logic [DW-1:0]          r6_disc;

    assign w_c[0] = i_cx;
    assign w_c[1] = i_cy;
    assign w_c[2] = i_cz;

    always_comb begin
        w_o[0] = sat_cw(64'(i_ray.ox), CW);
        w_o[1] = sat_cw(64'(i_ray.oy), CW);
        w_o[2] = sat_cw(64'(i_ray.oz), CW);
        w_d[0] = sat_cw(64'(i_ray.dx), CW);
        w_d[1] = sat_cw(64'(i_ray.dy), CW);
        w_d[2] = sat_cw(64'(i_ray.dz), CW);
        w_ray  = '{ox: w_o[0], oy: w_o[1], oz: w_o[2], dx: w_d[0], dy: w_d[1], dz: w_d[2]};
        for (int i = 0; i < 3; i++) begin
            w_oc[i] = (XW+1)'(w_o[i]) - (XW+1)'(w_c[i]);
        end
    end

    always_comb begin
        w_habs = r3_h[HW-1] ? HW'(-r3_h) : HW'(r3_h);
        w_cabs = r3_c[HW-1] ? HW'(-r3_c) : HW'(r3_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // stage 1: saturate, offset from center
            r1_ray <= w_ray;
            for (int i = 0; i < 3; i++) begin
                r1_d[i]     <= w_d[i];
                r1_oc[i]    <= w_oc[i];
                r1_ocabs[i] <= w_oc[i][XW] ? (XW+1)'(-w_oc[i]) : (XW+1)'(w_oc[i]);
            end
            // stage 2: per-axis products
            r2_ray <= r1_ray;
            for (int i = 0; i < 3; i++) begin
                r2_dd[i]  <= $unsigned(64'(r1_d[i]) * 64'(r1_d[i]));
                r2_doc[i] <= (2*XW+1)'(r1_d[i]) * (2*XW+1)'(r1_oc[i]);
                r2_oc2[i] <= (2*XW+2)'(r1_ocabs[i]) * (2*XW+2)'(r1_ocabs[i]);
            end
            r2_rr <= (2*RW)'(i_radius) * (2*RW)'(i_radius);
            // stage 3: floor each product to Q16.16, then sum
            r3_ray <= r2_ray;
            r3_a   <= r2_dd[0][63:16] + r2_dd[1][63:16] + r2_dd[2][63:16];
            r3_h   <= HW'($signed(r2_doc[0][2*XW:16])) + HW'($signed(r2_doc[1][2*XW:16]))
                    + HW'($signed(r2_doc[2][2*XW:16]));
            r3_c   <= HW'(r2_oc2[0][2*XW+1:16]) + HW'(r2_oc2[1][2*XW+1:16])
                    + HW'(r2_oc2[2][2*XW+1:16]) - HW'(r2_rr[2*RW-1:16]);
            // stage 4: split partial products for H^2 and A*|C|
            r4_ray   <= r3_ray;
            r4_a     <= r3_a;
            r4_h     <= r3_h;
            r4_cle0  <= r3_c[HW-1] || (r3_c == '0);
            r4_azero <= (r3_a == '0);
            r4_hll   <= w_habs[LW-1:0] * w_habs[LW-1:0];
            r4_hlh   <= w_habs[LW-1:0] * w_habs[HW-1:LW];
            r4_hhh   <= w_habs[HW-1:LW] * w_habs[HW-1:LW];
            r4_acll  <= r3_a[LW-1:0] * w_cabs[LW-1:0];
            r4_aclh  <= r3_a[LW-1:0] * w_cabs[HW-1:LW];
            r4_achl  <= r3_a[AW-1:LW] * w_cabs[LW-1:0];
            r4_achh  <= r3_a[AW-1:LW] * w_cabs[HW-1:LW];
            // stage 5: assemble
            r5_ray   <= r4_ray;
            r5_a     <= r4_a;
            r5_h     <= r4_h;
            r5_cle0  <= r4_cle0;
            r5_azero <= r4_azero;
            r5_h2    <= (PW'(r4_hhh) << (2*LW)) + (PW'(r4_hlh) << (LW+1)) + PW'(r4_hll);
            r5_ac    <= (PW'(r4_achh) << (2*LW)) + ((PW'(r4_aclh) + PW'(r4_achl)) << LW)
                      + PW'(r4_acll);
            // stage 6: discriminant, miss on flat direction or negative value
            r6_side.ray <= r5_ray;
            r6_side.a   <= r5_a;
            r6_side.h   <= r5_h;
            if (r5_cle0) begin
                r6_disc      <= DW'(r5_h2 + r5_ac);
                r6_side.miss <= r5_azero;
            end else begin
                r6_disc      <= DW'(r5_h2 - r5_ac);
                r6_side.miss <= r5_azero || (r5_ac > r5_h2);
            end
        end
    end

    assign o_vld  = r_vld[5];
    assign o_side = r6_side;
    assign o_disc = r6_disc;

endmodule

@@ rtl/core/rsi_sqrt.sv @@
// Pipelined floor square root of the discriminant, one result bit per stage.
// Carries the ray side band alongside; uses rsi_pkg.
module rsi_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_vld,
    input  rsi_pkg::t_sq_side        i_side,
    input  logic [rsi_pkg::DW-1:0]   i_disc,
    output logic                     o_vld,
    output rsi_pkg::t_sq_side        o_side,
    output logic [rsi_pkg::SW-1:0]   o_root
);
    import rsi_pkg::*;

    logic [SW:0]    r_vld;
    logic [DW-1:0]  r_rem  [SW+1];
    logic [SW-1:0]  r_root [SW+1];
    t_sq_side       r_side [SW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[SW-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0]  <= i_disc;
            r_root[0] <= '0;
            r_side[0] <= i_side;
            for (int g = 1; g <= SW; g++) begin
                // try root bit SW-g: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
                r_side[g] <= r_side[g-1];
                if (r_rem[g-1] >= (DW'(r_root[g-1]) << (SW - g + 1))
                                  + (DW'(1) << (2*(SW - g)))) begin
                    r_rem[g]  <= r_rem[g-1] - (DW'(r_root[g-1]) << (SW - g + 1))
                                            - (DW'(1) << (2*(SW - g)));
                    r_root[g] <= r_root[g-1] | (SW'(1) << (SW - g));
                end else begin
                    r_rem[g]  <= r_rem[g-1];
                    r_root[g] <= r_root[g-1];
                end
            end
        end
    end

    assign o_vld  = r_vld[SW];
    assign o_side = r_side[SW];
    assign o_root = r_root[SW];

endmodule

@@ rtl/core/rsi_div.sv @@
// Root numerators and two pipelined restoring dividers giving t = n / A in Q16.16.
// One quotient bit per stage per lane; uses rsi_pkg.
module rsi_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_vld,
    input  rsi_pkg::t_sq_side        i_side,
    input  logic [rsi_pkg::SW-1:0]   i_root,
    output logic                     o_vld,
    output logic                     o_hit,
    output rsi_pkg::t_ray            o_ray,
    output logic [rsi_pkg::TW-1:0]   o_t_near,
    output logic [rsi_pkg::TW-1:0]   o_t_far
);
    import rsi_pkg::*;

    localparam int RMW = NW + 16;
    localparam int DVW = AW + TW;

    logic signed [NW:0] w_hx, w_sx, w_n1, w_n2;
    logic               w_hit;
    logic [NW-1:0]      w_num [2];
    logic [TW:0]        r_vld;
    logic [RMW-1:0]     r_rem [TW+1][2];
    logic [TW-1:0]      r_q   [TW+1][2];
    logic [1:0]         r_sat [TW+1];
    logic               r_hit [TW+1];
    logic [AW-1:0]      r_a   [TW+1];
    t_ray               r_ray [TW+1];

    always_comb begin
        w_hx  = (NW+1)'(i_side.h);
        w_sx  = $signed((NW+1)'(i_root));
        w_n1  = -w_hx - w_sx;
        w_n2  = -w_hx + w_sx;
        w_hit = !i_side.miss && !w_n2[NW];
        // origin inside the sphere: both results take the far root
        w_num[0] = w_hit ? (w_n1[NW] ? w_n2[NW-1:0] : w_n1[NW-1:0]) : '0;
        w_num[1] = w_hit ? w_n2[NW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[TW-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_hit[0] <= w_hit;
            r_a[0]   <= i_side.a;
            r_ray[0] <= i_side.ray;
            for (int l = 0; l < 2; l++) begin
                r_rem[0][l] <= {w_num[l], 16'b0};
                r_q[0][l]   <= '0;
                r_sat[0][l] <= (64'(w_num[l]) >= {i_side.a, 16'b0});
            end
            for (int g = 1; g <= TW; g++) begin
                r_hit[g] <= r_hit[g-1];
                r_a[g]   <= r_a[g-1];
                r_ray[g] <= r_ray[g-1];
                r_sat[g] <= r_sat[g-1];
                for (int l = 0; l < 2; l++) begin
                    if (DVW'(r_rem[g-1][l]) >= (DVW'(r_a[g-1]) << (TW - g))) begin
                        r_rem[g][l] <= r_rem[g-1][l] - RMW'(DVW'(r_a[g-1]) << (TW - g));
                        r_q[g][l]   <= r_q[g-1][l] | (TW'(1) << (TW - g));
                    end else begin
                        r_rem[g][l] <= r_rem[g-1][l];
                        r_q[g][l]   <= r_q[g-1][l];
                    end
                end
            end
        end
    end

    assign o_vld    = r_vld[TW];
    assign o_hit    = r_hit[TW];
    assign o_ray    = r_ray[TW];
    assign o_t_near = r_sat[TW][0] ? '1 : r_q[TW][0];
    assign o_t_far  = r_sat[TW][1] ? '1 : r_q[TW][1];

endmodule

@@ rtl/core/rsi_point.sv @@
// Hit points O + t*D and normals point - center for the near and far roots.
// Three register stages; uses rsi_pkg.
module rsi_point #(
    parameter int CW = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_vld,
    input  logic                     i_hit,
    input  rsi_pkg::t_ray            i_ray,
    input  logic [rsi_pkg::TW-1:0]   i_t_near,
    input  logic [rsi_pkg::TW-1:0]   i_t_far,
    input  rsi_pkg::t_coord          i_cx,
    input  rsi_pkg::t_coord          i_cy,
    input  rsi_pkg::t_coord          i_cz,
    output logic                     o_vld,
    output rsi_pkg::t_result         o_near,
    output rsi_pkg::t_result         o_far
);
    import rsi_pkg::*;

    t_coord                   w_o [3];
    t_coord                   w_d [3];
    t_coord                   w_c [3];
    logic [TW-1:0]            w_t [2];
    logic [2:0]               r_vld;
    logic                     r1_hit, r2_hit;
    t_coord                   r1_o [3];
    logic signed [2*XW:0]     r1_prod [2][3];
    logic signed [XW+17:0]    r2_w [2][3];
    t_coord                   w_pt [2][3];
    t_coord                   w_nm [2][3];
    t_result                  r3_res [2];

    assign w_o[0] = i_ray.ox;
    assign w_o[1] = i_ray.oy;
    assign w_o[2] = i_ray.oz;
    assign w_d[0] = i_ray.dx;
    assign w_d[1] = i_ray.dy;
    assign w_d[2] = i_ray.dz;
    assign w_c[0] = i_cx;
    assign w_c[1] = i_cy;
    assign w_c[2] = i_cz;
    assign w_t[0] = i_t_near;
    assign w_t[1] = i_t_far;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int i = 0; i < 3; i++) begin
                w_pt[l][i] = sat_cw(64'(r2_w[l][i]), CW);
                w_nm[l][i] = sat_cw(64'((XW+19)'(r2_w[l][i]) - (XW+19)'(w_c[i])), CW);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_hit <= i_hit;
            for (int i = 0; i < 3; i++) begin
                r1_o[i] <= w_o[i];
                for (int l = 0; l < 2; l++) begin
                    r1_prod[l][i] <= (2*XW+1)'($signed({1'b0, w_t[l]})) * (2*XW+1)'(w_d[i]);
                end
            end
            r2_hit <= r1_hit;
            for (int l = 0; l < 2; l++) begin
                for (int i = 0; i < 3; i++) begin
                    r2_w[l][i] <= (XW+18)'(r1_o[i]) + (XW+18)'($signed(r1_prod[l][i][2*XW:16]));
                end
            end
            // misses report zero point and normal
            for (int l = 0; l < 2; l++) begin
                r3_res[l].hit <= r2_hit;
                r3_res[l].px  <= r2_hit ? w_pt[l][0] : '0;
                r3_res[l].py  <= r2_hit ? w_pt[l][1] : '0;
                r3_res[l].pz  <= r2_hit ? w_pt[l][2] : '0;
                r3_res[l].nx  <= r2_hit ? w_nm[l][0] : '0;
                r3_res[l].ny  <= r2_hit ? w_nm[l][1] : '0;
                r3_res[l].nz  <= r2_hit ? w_nm[l][2] : '0;
            end
        end
    end

    assign o_vld  = r_vld[2];
    assign o_near = r3_res[0];
    assign o_far  = r3_res[1];

endmodule

@@ rtl/core/ray_sphere_intersect_unit.sv @@
// Ray/sphere intersection top level: APB registers, pipeline and result serializer.
// Depends on rsi_pkg, rsi_quad, rsi_sqrt, rsi_div and rsi_point.
//
//  channel   direction  handshake                      payload
//  ray       in         i_in_valid / o_in_stall        i_origin_*, i_dir_*
//  result    out        o_out_valid / i_out_stall      o_hit, o_point_*, o_normal_*, o_is_far
//  config    in         APB psel/penable/pwrite        center_x/y/z, radius at 0x0..0xC
//
// The near result of a ray is sent first; the far result follows it.
// Each ray leaves as two result transactions, so the output port limits the sustained ray rate;
// the pipeline itself takes a ray every cycle unless the serializer still owes a result.
// A stall on the result side freezes every stage together; nothing is dropped or repeated.
// Reset clears the valid bits and loads center 0 and radius 1.0.
module ray_sphere_intersect_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  rsi_pkg::t_coord            i_origin_x,
    input  rsi_pkg::t_coord            i_origin_y,
    input  rsi_pkg::t_coord            i_origin_z,
    input  rsi_pkg::t_coord            i_dir_x,
    input  rsi_pkg::t_coord            i_dir_y,
    input  rsi_pkg::t_coord            i_dir_z,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_hit,
    output rsi_pkg::t_coord            o_point_x,
    output rsi_pkg::t_coord            o_point_y,
    output rsi_pkg::t_coord            o_point_z,
    output rsi_pkg::t_coord            o_normal_x,
    output rsi_pkg::t_coord            o_normal_y,
    output rsi_pkg::t_coord            o_normal_z,
    output logic                       o_is_far,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rsi_pkg::PAW-1:0]    paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rsi_pkg::*;

    localparam int CW = (COORD_WIDTH < XW) ? COORD_WIDTH : XW;

    t_coord         r_center_x, r_center_y, r_center_z;
    logic [RW-1:0]  r_radius;
    t_coord         w_cx, w_cy, w_cz;
    t_ray           w_in_ray;
    logic           w_adv, w_cfg_we;
    logic           q_vld, s_vld, d_vld, p_vld, d_hit;
    t_sq_side       q_side, s_side;
    logic [DW-1:0]  q_disc;
    logic [SW-1:0]  s_root;
    t_ray           d_ray;
    logic [TW-1:0]  d_t_near, d_t_far;
    t_result        p_near, p_far;
    logic           r_full, r_sel;
    t_result        r_near, r_far;
    t_result        w_res;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= RW'(32'h0001_0000);
        end else if (w_cfg_we) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_CENTER_X: r_center_x <= pwdata;
                REG_CENTER_Y: r_center_y <= pwdata;
                REG_CENTER_Z: r_center_z <= pwdata;
                REG_RADIUS:   r_radius   <= pwdata[RW-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_CENTER_X: prdata = r_center_x;
            REG_CENTER_Y: prdata = r_center_y;
            REG_CENTER_Z: prdata = r_center_z;
            REG_RADIUS:   prdata = {1'b0, r_radius};
            default:      prdata = '0;
        endcase
    end

    assign w_cx = sat_cw(64'(r_center_x), CW);
    assign w_cy = sat_cw(64'(r_center_y), CW);
    assign w_cz = sat_cw(64'(r_center_z), CW);

    assign w_in_ray = '{ox: i_origin_x, oy: i_origin_y, oz: i_origin_z,
                        dx: i_dir_x, dy: i_dir_y, dz: i_dir_z};

    // advance the whole pipeline unless the serializer still owes a result
    assign w_adv      = !r_full || (r_sel && !i_out_stall);
    assign o_in_stall = !w_adv;

    rsi_quad #(.CW(CW)) u_quad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_vld    (i_in_valid),
        .i_ray    (w_in_ray),
        .i_cx     (w_cx),
        .i_cy     (w_cy),
        .i_cz     (w_cz),
        .i_radius (r_radius),
        .o_vld    (q_vld),
        .o_side   (q_side),
        .o_disc   (q_disc)
    );

    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (q_vld),
        .i_side  (q_side),
        .i_disc  (q_disc),
        .o_vld   (s_vld),
        .o_side  (s_side),
        .o_root  (s_root)
    );

    rsi_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_vld    (s_vld),
        .i_side   (s_side),
        .i_root   (s_root),
        .o_vld    (d_vld),
        .o_hit    (d_hit),
        .o_ray    (d_ray),
        .o_t_near (d_t_near),
        .o_t_far  (d_t_far)
    );

    rsi_point #(.CW(CW)) u_point (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_vld    (d_vld),
        .i_hit    (d_hit),
        .i_ray    (d_ray),
        .i_t_near (d_t_near),
        .i_t_far  (d_t_far),
        .i_cx     (w_cx),
        .i_cy     (w_cy),
        .i_cz     (w_cz),
        .o_vld    (p_vld),
        .o_near   (p_near),
        .o_far    (p_far)
    );

    // result serializer: near transaction, then far
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_sel  <= 1'b0;
        end else if (w_adv) begin
            r_full <= p_vld;
            r_sel  <= 1'b0;
        end else if (r_full && !i_out_stall) begin
            r_sel <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && p_vld) begin
            r_near <= p_near;
            r_far  <= p_far;
        end
    end

    assign w_res       = r_sel ? r_far : r_near;
    assign o_out_valid = r_full;
    assign o_is_far    = r_sel;
    assign o_hit       = w_res.hit;
    assign o_point_x   = w_res.px;
    assign o_point_y   = w_res.py;
    assign o_point_z   = w_res.pz;
    assign o_normal_x  = w_res.nx;
    assign o_normal_y  = w_res.ny;
    assign o_normal_z  = w_res.nz;

    a_far_follows_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_far && !i_out_stall |=> o_out_valid && o_is_far)
        else $error("near result not followed by far result");

    a_drop_after_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(o_out_valid) |-> $past(o_is_far && !i_out_stall))
        else $error("result pair dropped before far transaction");

    a_pair_hit_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_near.hit == r_far.hit)
        else $error("near and far hit flags disagree");

    a_stall_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_point_x == '0 && o_normal_z == '0)
        else $error("miss result carries nonzero payload");

endmodule
